### hdl/suffix_automaton_builder_unit_defines.svh
// Assertion macros used by the top-level file that checks this block.
`ifndef SUFFIX_AUTOMATON_BUILDER_UNIT_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define SAB_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sab assertion failed");
// Antecedent implies consequent in the next cycle.
`define SAB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sab assertion failed");
`else
`define SAB_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define SAB_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### hdl/sab_pkg.sv
`default_nettype none
package sab_pkg;
	localparam int MAX_STATES_DEF = 2048;
	localparam int ALPHABET_DEF = 26;
	localparam int OP_W = 2;
	localparam int SYM_W = 5;
	localparam int NODE_W = 11;
	localparam int STAT_W = 2;
	localparam int LEN_W = 10;
	localparam int LENGTH_MAX = 1023;

	typedef enum logic [OP_W-1:0] {
		OP_RESTART    = 2'd0,
		OP_APPEND     = 2'd1,
		OP_READ_TRANS = 2'd2,
		OP_READ_LINK  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_NODE = 2'd2
	} stat_t;

	typedef enum logic [17:0] {
		S_IDLE  = 18'h00001,
		S_INIT  = 18'h00002,
		S_RD    = 18'h00004,
		S_RDW   = 18'h00008,
		S_ALEN  = 18'h00010,
		S_ALENW = 18'h00020,
		S_ACLR  = 18'h00040,
		S_WRD   = 18'h00080,
		S_WCK   = 18'h00100,
		S_QRD   = 18'h00200,
		S_QRD2  = 18'h00400,
		S_QCK   = 18'h00800,
		S_CLNK  = 18'h01000,
		S_CLNK2 = 18'h02000,
		S_CCPY  = 18'h04000,
		S_RRD   = 18'h08000,
		S_RCK   = 18'h10000,
		S_DONE  = 18'h20000
	} step_t;

	typedef struct packed {
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic accept;
		op_t  op;
		logic sym_ok;
		logic full;
		logic in_use;
		logic busy;
		logic out_free;
		logic cnt_last;
		logic cnt_end;
		logic p_zero;
		logic t_zero;
		logic t_is_q;
		logic len_match;
	} sts_t;
endpackage
`default_nettype wire

### hdl/sab_in_if.sv
`default_nettype none
interface sab_in_if;
	import sab_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [SYM_W-1:0]  symbol;
	logic [NODE_W-1:0] node;
	modport source (output valid, operation, symbol, node, input ready);
	modport sink (input valid, operation, symbol, node, output ready);
endinterface
`default_nettype wire

### hdl/sab_out_if.sv
`default_nettype none
interface sab_out_if;
	import sab_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [NODE_W-1:0] next_node;
	logic [NODE_W-1:0] suffix_link;
	logic [LEN_W-1:0]  node_length;
	logic [NODE_W-1:0] node_count;
	logic [NODE_W-1:0] last_node;
	modport source (output valid, status, next_node, suffix_link, node_length, node_count,
		last_node, input ready);
	modport sink (input valid, status, next_node, suffix_link, node_length, node_count,
		last_node, output ready);
endinterface
`default_nettype wire

### hdl/suffix_automaton_builder_unit.sv
`default_nettype none
`include "suffix_automaton_builder_unit_defines.svh"
// Online suffix automaton builder. One word in gives one word out. A node or
// link read goes through a read step and a wait step; a restart clears the
// root row of the transition memory one entry a cycle (the same pass runs once
// after reset, during which no word is taken). An append clears the new node's
// row, then walks the suffix links toward the root, setting each missing
// transition, and reads the target's length when the walk stops on an existing
// transition. A clone copies that node's row, relinks it and redirects the
// transitions along the walk, paced by the single read and write port of the
// transition memory.
// A result that is not taken holds the block in its finishing step.
module suffix_automaton_builder_unit #(
	parameter int MAX_STATES = sab_pkg::MAX_STATES_DEF,
	parameter int ALPHABET = sab_pkg::ALPHABET_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sab_in_if.sink    items,
	sab_out_if.source results
);
	import sab_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	sab_dpath #(.MAX_STATES(MAX_STATES), .ALPHABET(ALPHABET)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .items(items), .results(results)
	);

	// An accepted word always leaves idle and is tracked as pending
	`SAB_ASSERT_NEXT(a_accept_busy, clk, arst_n, sts.accept, sts.busy && cmd.step != S_IDLE)
	// The whole-string node is never above the highest node in use
	`SAB_ASSERT_SAME(a_last_in_range, clk, arst_n, results.valid, results.last_node <= results.node_count)
	// Results are only loaded from the finishing step
	`SAB_ASSERT_NEXT(a_load_done, clk, arst_n, !results.valid, !results.valid || $past(cmd.step) == S_DONE)
endmodule
`default_nettype wire

### hdl/sab_ram.sv
`default_nettype none
module sab_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]              rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

### hdl/sab_ctrl.sv
`default_nettype none
module sab_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire sab_pkg::sts_t sts,
	output sab_pkg::cmd_t     cmd
);
	import sab_pkg::*;

	step_t state_q, state_d;

	// Sequence the operation steps
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sts.accept) begin
					case (sts.op)
						OP_RESTART: state_d = S_INIT;
						OP_APPEND: state_d = (!sts.sym_ok || sts.full) ? S_DONE : S_ALEN;
						default: state_d = sts.in_use ? S_RD : S_DONE;
					endcase
				end
			end
			S_INIT: if (sts.cnt_last) state_d = S_DONE;
			S_RD: state_d = S_RDW;
			S_RDW: state_d = S_DONE;
			S_ALEN: state_d = S_ALENW;
			S_ALENW: state_d = S_ACLR;
			S_ACLR: if (sts.cnt_last) state_d = S_WRD;
			S_WRD: state_d = sts.p_zero ? S_DONE : S_WCK;
			S_WCK: state_d = sts.t_zero ? S_WRD : S_QRD;
			S_QRD: state_d = S_QRD2;
			S_QRD2: state_d = S_QCK;
			S_QCK: state_d = sts.len_match ? S_DONE : S_CLNK;
			S_CLNK: state_d = S_CLNK2;
			S_CLNK2: state_d = S_CCPY;
			S_CCPY: if (sts.cnt_end) state_d = S_RRD;
			S_RRD: state_d = sts.p_zero ? S_DONE : S_RCK;
			S_RCK: state_d = sts.t_is_q ? S_RRD : S_DONE;
			S_DONE: if (!sts.busy || sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the state; come out of reset clearing the root row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.step = state_q;
endmodule
`default_nettype wire

### hdl/sab_dpath.sv
`default_nettype none
module sab_dpath #(
	parameter int MAX_STATES = sab_pkg::MAX_STATES_DEF,
	parameter int ALPHABET = sab_pkg::ALPHABET_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sab_pkg::cmd_t cmd,
	output sab_pkg::sts_t      sts,
	sab_in_if.sink             items,
	sab_out_if.source          results
);
	import sab_pkg::*;

	localparam int NW = $clog2(MAX_STATES);
	localparam int CW = $clog2(ALPHABET + 1);
	localparam int TD = MAX_STATES * ALPHABET;
	localparam int TAW = $clog2(TD);

	// Row base times alphabet plus letter gives the transition entry
	function automatic logic [TAW-1:0] taddr(input logic [NW-1:0] n, input logic [CW-1:0] i);
		return TAW'(32'(n) * 32'(ALPHABET) + 32'(i));
	endfunction

	logic            accept;
	logic            sym_ok_in, full_in, in_use_in;
	op_t             op_in;
	logic [NW-1:0]   highest_q, last_q, p_q, cur_q, q_q, clone_q, n_q;
	logic [LEN_W-1:0] slen_q, lenp_q;
	logic [CW-1:0]   cnt_q, sym_q;
	op_t             op_q;
	logic            sym_ok_q, busy_q;
	stat_t           res_stat_q;
	logic [NW-1:0]   res_next_q, res_link_q;
	logic [LEN_W-1:0] res_len_q;
	logic            out_valid_q, out_free;
	stat_t           out_stat_q;
	logic [NW-1:0]   out_next_q, out_link_q, out_count_q, out_last_q;
	logic [LEN_W-1:0] out_len_q;

	logic            t_we, l_we, g_we;
	logic [TAW-1:0]  t_wa, t_ra;
	logic [NW-1:0]   l_wa, l_ra, g_wa, g_ra;
	logic [NW-1:0]   t_wd, t_rd, l_wd, l_rd;
	logic [LEN_W-1:0] g_wd, g_rd;

	// Decode the offered word
	assign items.ready = (cmd.step == S_IDLE);
	assign accept = items.valid && items.ready;
	assign op_in = op_t'(items.operation);
	assign sym_ok_in = 32'(items.symbol) < 32'(ALPHABET);
	assign full_in = (32'(highest_q) + 32'd2 >= 32'(MAX_STATES)) ||
		(32'(slen_q) >= 32'(LENGTH_MAX));
	assign in_use_in = (32'(items.node) >= 32'd1) && (32'(items.node) <= 32'(highest_q));
	assign out_free = !out_valid_q || results.ready;

	assign sts.accept = accept;
	assign sts.op = op_in;
	assign sts.sym_ok = sym_ok_in;
	assign sts.full = full_in;
	assign sts.in_use = in_use_in;
	assign sts.busy = busy_q;
	assign sts.out_free = out_free;
	assign sts.cnt_last = (cnt_q == CW'(ALPHABET - 1));
	assign sts.cnt_end = (cnt_q == CW'(ALPHABET));
	assign sts.p_zero = (p_q == '0);
	assign sts.t_zero = (t_rd == '0);
	assign sts.t_is_q = (t_rd == q_q);
	assign sts.len_match = (g_rd == lenp_q + LEN_W'(1));

	// Drive the memory ports for each step
	always_comb begin
		t_we = 1'b0;
		t_wa = taddr(p_q, sym_q);
		t_wd = '0;
		t_ra = taddr(p_q, sym_q);
		l_we = 1'b0;
		l_wa = cur_q;
		l_wd = '0;
		l_ra = p_q;
		g_we = 1'b0;
		g_wa = cur_q;
		g_wd = '0;
		g_ra = p_q;
		case (cmd.step)
			S_INIT: begin
				t_we = 1'b1;
				t_wa = taddr(NW'(1), cnt_q);
				if (cnt_q == '0) begin
					l_we = 1'b1;
					l_wa = NW'(1);
					g_we = 1'b1;
					g_wa = NW'(1);
				end
			end
			S_RD: begin
				t_ra = taddr(n_q, sym_q);
				l_ra = n_q;
				g_ra = n_q;
			end
			S_ALENW: begin
				g_we = 1'b1;
				g_wd = g_rd + LEN_W'(1);
			end
			S_ACLR: begin
				t_we = 1'b1;
				t_wa = taddr(cur_q, cnt_q);
			end
			S_WRD: begin
				if (p_q == '0) begin
					l_we = 1'b1;
					l_wd = NW'(1);
				end
			end
			S_WCK: begin
				if (t_rd == '0) begin
					t_we = 1'b1;
					t_wd = cur_q;
				end
			end
			S_QRD2: g_ra = q_q;
			S_QCK: begin
				l_we = 1'b1;
				l_ra = q_q;
				if (g_rd == lenp_q + LEN_W'(1)) begin
					l_wd = q_q;
				end else begin
					l_wd = highest_q + NW'(1);
					g_we = 1'b1;
					g_wa = highest_q + NW'(1);
					g_wd = lenp_q + LEN_W'(1);
				end
			end
			S_CLNK: begin
				l_we = 1'b1;
				l_wa = clone_q;
				l_wd = l_rd;
			end
			S_CLNK2: begin
				l_we = 1'b1;
				l_wa = q_q;
				l_wd = clone_q;
			end
			S_CCPY: begin
				t_ra = taddr(q_q, cnt_q);
				if (cnt_q != '0) begin
					t_we = 1'b1;
					t_wa = taddr(clone_q, cnt_q - CW'(1));
					t_wd = t_rd;
				end
			end
			S_RCK: begin
				if (t_rd == q_q) begin
					t_we = 1'b1;
					t_wd = clone_q;
				end
			end
			default: begin
			end
		endcase
	end

	sab_ram #(.WIDTH(NW), .DEPTH(TD)) u_trans (
		.clk(clk), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd)
	);
	sab_ram #(.WIDTH(NW), .DEPTH(MAX_STATES)) u_link (
		.clk(clk), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra), .rd_data(l_rd)
	);
	sab_ram #(.WIDTH(LEN_W), .DEPTH(MAX_STATES)) u_len (
		.clk(clk), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd), .rd_addr(g_ra), .rd_data(g_rd)
	);

	// Advance control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= NW'(1);
			last_q <= NW'(1);
			slen_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step == S_DONE && busy_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.step)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						busy_q <= 1'b1;
						if (op_in == OP_RESTART) begin
							highest_q <= NW'(1);
							last_q <= NW'(1);
							slen_q <= '0;
						end else if (op_in == OP_APPEND && sym_ok_in && !full_in) begin
							highest_q <= highest_q + NW'(1);
							last_q <= highest_q + NW'(1);
							slen_q <= slen_q + LEN_W'(1);
						end
					end
				end
				S_INIT, S_ACLR, S_CCPY: cnt_q <= cnt_q + CW'(1);
				S_ALENW, S_CLNK2: cnt_q <= '0;
				S_QCK: begin
					if (g_rd != lenp_q + LEN_W'(1)) begin
						highest_q <= highest_q + NW'(1);
					end
				end
				S_DONE: begin
					if (busy_q && out_free) begin
						busy_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the walk pointers and the result
	always_ff @(posedge clk) begin
		case (cmd.step)
			S_IDLE: begin
				if (accept) begin
					op_q <= op_in;
					sym_q <= CW'(items.symbol);
					sym_ok_q <= sym_ok_in;
					n_q <= NW'(items.node);
					p_q <= last_q;
					cur_q <= highest_q + NW'(1);
					res_next_q <= '0;
					res_link_q <= '0;
					res_len_q <= '0;
					if (op_in == OP_APPEND && sym_ok_in && full_in) begin
						res_stat_q <= ST_FULL;
					end else if ((op_in == OP_READ_TRANS || op_in == OP_READ_LINK) &&
						!in_use_in) begin
						res_stat_q <= ST_BAD_NODE;
					end else begin
						res_stat_q <= ST_OK;
					end
				end
			end
			S_RDW: begin
				if (op_q == OP_READ_TRANS) begin
					res_next_q <= sym_ok_q ? t_rd : '0;
				end else begin
					res_link_q <= l_rd;
					res_len_q <= g_rd;
				end
			end
			S_WCK: begin
				if (t_rd == '0) begin
					p_q <= l_rd;
				end else begin
					q_q <= t_rd;
				end
			end
			S_QRD2: lenp_q <= g_rd;
			S_QCK: clone_q <= highest_q + NW'(1);
			S_RCK: begin
				if (t_rd == q_q) begin
					p_q <= l_rd;
				end
			end
			S_DONE: begin
				if (busy_q && out_free) begin
					out_stat_q <= res_stat_q;
					out_next_q <= res_next_q;
					out_link_q <= res_link_q;
					out_len_q <= res_len_q;
					out_count_q <= highest_q;
					out_last_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.status = out_stat_q;
	assign results.next_node = NODE_W'(out_next_q);
	assign results.suffix_link = NODE_W'(out_link_q);
	assign results.node_length = out_len_q;
	assign results.node_count = NODE_W'(out_count_q);
	assign results.last_node = NODE_W'(out_last_q);
endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import sab_pkg::*;

	localparam int NSTATES = MAX_STATES_DEF;
	localparam int NLET = ALPHABET_DEF;
	localparam int CYCLE_LIMIT = 2500000;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [NODE_W-1:0] next_node;
		logic [NODE_W-1:0] suffix_link;
		logic [LEN_W-1:0]  node_length;
		logic [NODE_W-1:0] node_count;
		logic [NODE_W-1:0] last_node;
	} word_out_t;

	typedef struct packed {
		op_t               op;
		logic [SYM_W-1:0]  sym;
		logic [NODE_W-1:0] node;
		logic              typed;
		word_out_t         want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sab_in_if  in_ch();
	sab_out_if out_ch();

	suffix_automaton_builder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(in_ch),
		.results(out_ch)
	);

	always #4 clk = ~clk;

	// automaton shadow
	logic [NODE_W-1:0] sh_trans [NSTATES*NLET];
	logic [NODE_W-1:0] sh_link [NSTATES];
	logic [LEN_W-1:0]  sh_len [NSTATES];
	int unsigned       sh_high, sh_whole, sh_strlen;

	word_out_t   pending_words [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_idle = 0, recv_idle = 0;
	int unsigned hold_gen = 0;

	task automatic shadow_clear();
		for (int i = 0; i < NSTATES*NLET; i++) sh_trans[i] = '0;
		for (int i = 0; i < NSTATES; i++) begin
			sh_link[i] = '0;
			sh_len[i] = '0;
		end
		sh_high = 1;
		sh_whole = 1;
		sh_strlen = 0;
	endtask

	task automatic shadow_append(input int unsigned c);
		int unsigned p, cur, q, cl;
		p = sh_whole;
		cur = sh_high + 1;
		sh_high = cur;
		sh_whole = cur;
		sh_strlen++;
		sh_len[cur] = sh_len[p] + 1;
		// walk links, fill missing edges
		while (p != 0 && sh_trans[p*NLET+c] == 0) begin
			sh_trans[p*NLET+c] = cur;
			p = sh_link[p];
		end
		if (p == 0) begin
			sh_link[cur] = 1;
			return;
		end
		q = sh_trans[p*NLET+c];
		if (sh_len[q] == sh_len[p] + 1) begin
			sh_link[cur] = q;
			return;
		end
		// split q with a clone
		cl = sh_high + 1;
		sh_high = cl;
		for (int i = 0; i < NLET; i++) sh_trans[cl*NLET+i] = sh_trans[q*NLET+i];
		sh_link[cl] = sh_link[q];
		sh_len[cl] = sh_len[p] + 1;
		sh_link[cur] = cl;
		sh_link[q] = cl;
		while (p != 0 && sh_trans[p*NLET+c] == q) begin
			sh_trans[p*NLET+c] = cl;
			p = sh_link[p];
		end
	endtask

	task automatic automaton_step(input op_t op, input logic [SYM_W-1:0] sym,
		input logic [NODE_W-1:0] n, output word_out_t w);
		bit in_use;
		in_use = (n >= 1 && n <= sh_high);
		w = '0;
		w.status = ST_OK;
		case (op)
			OP_RESTART: begin
				shadow_clear();
			end
			OP_APPEND: begin
				if (sym < NLET) begin
					if (sh_high + 2 >= NSTATES || sh_strlen >= LENGTH_MAX)
						w.status = ST_FULL;
					else
						shadow_append(sym);
				end
			end
			default: begin
				if (!in_use)
					w.status = ST_BAD_NODE;
				else if (op == OP_READ_TRANS) begin
					if (sym < NLET) w.next_node = sh_trans[n*NLET+sym];
				end else begin
					w.suffix_link = sh_link[n];
					w.node_length = sh_len[n];
				end
			end
		endcase
		w.node_count = sh_high;
		w.last_node = sh_whole;
	endtask

	// offer one word; valid stays high across back-to-back words
	task automatic offer_word(input op_t op, input logic [SYM_W-1:0] sym,
		input logic [NODE_W-1:0] n, input bit typed, input word_out_t want);
		word_out_t w;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.operation = op;
		in_ch.symbol = sym;
		in_ch.node = n;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		automaton_step(op, sym, n, w);
		pending_words.push_back(typed ? want : w);
	endtask

	task automatic offer(input op_t op, input logic [SYM_W-1:0] sym,
		input logic [NODE_W-1:0] n);
		offer_word(op, sym, n, 1'b0, '0);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pending_words.size() == 0);
	endtask

	// pick a node to read, mostly in or just around the range in use
	function automatic logic [NODE_W-1:0] pick_node();
		if ($urandom_range(0, 4) == 0) return NODE_W'($urandom_range(0, 2047));
		return NODE_W'($urandom_range(0, sh_high + 2));
	endfunction

	task automatic random_phase(input int unsigned count, input int unsigned alph_hi);
		int unsigned k, a;
		op_t op;
		logic [SYM_W-1:0] s;
		k = 0;
		a = 2;
		while (k < count) begin
			// start a fresh string now and then
			if ($urandom_range(0, 39) == 0) begin
				a = $urandom_range(2, alph_hi);
				op = OP_RESTART;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: op = OP_APPEND;
					6, 7: op = OP_READ_TRANS;
					default: op = OP_READ_LINK;
				endcase
			end
			if ($urandom_range(0, 19) == 0) s = SYM_W'($urandom_range(0, 31));
			else s = SYM_W'($urandom_range(0, a - 1));
			offer(op, s, pick_node());
			k++;
		end
	endtask

	// receiver: random ready, long hold-offs on request
	initial begin
		int unsigned seen, hold_left;
		seen = 0;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_gen != seen) begin
				seen = hold_gen;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else
				out_ch.ready = ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		word_out_t got, w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.status = out_ch.status;
			got.next_node = out_ch.next_node;
			got.suffix_link = out_ch.suffix_link;
			got.node_length = out_ch.node_length;
			got.node_count = out_ch.node_count;
			got.last_node = out_ch.last_node;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", got);
			end else begin
				w = pending_words.pop_front();
				if (got !== w) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: want %p got %p", w, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	row_t dir_rows [$];

	task automatic add_row(input op_t op, input int sym, input int n, input bit typed,
		input int st, input int nx, input int lk, input int ln, input int cnt, input int last);
		row_t r;
		r.op = op;
		r.sym = SYM_W'(sym);
		r.node = NODE_W'(n);
		r.typed = typed;
		r.want.status = STAT_W'(st);
		r.want.next_node = NODE_W'(nx);
		r.want.suffix_link = NODE_W'(lk);
		r.want.node_length = LEN_W'(ln);
		r.want.node_count = NODE_W'(cnt);
		r.want.last_node = NODE_W'(last);
		dir_rows.push_back(r);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.operation = OP_RESTART;
		in_ch.symbol = '0;
		in_ch.node = '0;
		shadow_clear();

		// directed rows: typed where plain, else predicted
		add_row(OP_READ_LINK,  0, 1,    1, ST_OK,       0, 0, 0, 1, 1);
		add_row(OP_READ_LINK,  0, 0,    1, ST_BAD_NODE, 0, 0, 0, 1, 1);
		add_row(OP_READ_TRANS, 0, 2047, 1, ST_BAD_NODE, 0, 0, 0, 1, 1);
		add_row(OP_READ_TRANS, 31, 1,   1, ST_OK,       0, 0, 0, 1, 1);
		add_row(OP_APPEND,     31, 0,   1, ST_OK,       0, 0, 0, 1, 1);
		add_row(OP_APPEND,     26, 5,   1, ST_OK,       0, 0, 0, 1, 1);
		add_row(OP_APPEND,     0, 0,    1, ST_OK,       0, 0, 0, 2, 2);
		add_row(OP_READ_TRANS, 0, 1,    1, ST_OK,       2, 0, 0, 2, 2);
		add_row(OP_READ_LINK,  0, 2,    1, ST_OK,       0, 1, 1, 2, 2);
		add_row(OP_READ_LINK,  0, 3,    1, ST_BAD_NODE, 0, 0, 0, 2, 2);
		add_row(OP_APPEND,     25, 0,   0, 0, 0, 0, 0, 0, 0);
		add_row(OP_APPEND,     25, 0,   0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ_TRANS, 25, 1,   0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ_LINK,  0, 5,    0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ_LINK,  0, 4,    0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ_TRANS, 25, 3,   0, 0, 0, 0, 0, 0, 0);
		add_row(OP_APPEND,     0, 2047, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_READ_TRANS, 16, 2,   0, 0, 0, 0, 0, 0, 0);
		add_row(OP_RESTART,    31, 2047, 1, ST_OK,      0, 0, 0, 1, 1);
		add_row(OP_READ_TRANS, 0, 1,    1, ST_OK,       0, 0, 0, 1, 1);
		add_row(OP_READ_LINK,  0, 2,    1, ST_BAD_NODE, 0, 0, 0, 1, 1);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 32;
		recv_idle = 72;
		foreach (dir_rows[i])
			offer_word(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].node,
				dir_rows[i].typed, dir_rows[i].want);

		// long receiver hold-off while words keep coming
		hold_gen++;
		random_phase(20, 4);
		random_phase(40, 26);
		drain();

		send_idle = 72;
		recv_idle = 32;
		random_phase(40, 3);
		drain();

		// no idling: build one long string until the builder refuses
		send_idle = 0;
		recv_idle = 0;
		offer(OP_RESTART, 0, 0);
		for (int i = 0; i < 1040; i++) begin
			if ($urandom_range(0, 63) == 0) offer(OP_READ_LINK, 0, pick_node());
			else if ($urandom_range(0, 63) == 0)
				offer(OP_READ_TRANS, SYM_W'($urandom_range(0, 25)), pick_node());
			offer(OP_APPEND, SYM_W'($urandom_range(0, 2)), NODE_W'($urandom_range(0, 2047)));
		end
		offer(OP_APPEND, 25, 0);
		offer(OP_READ_LINK, 0, 2047);
		offer(OP_RESTART, 0, 0);
		random_phase(20, 26);
		drain();

		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/sab_pkg.sv
hdl/sab_in_if.sv
hdl/sab_out_if.sv
hdl/sab_ram.sv
hdl/sab_ctrl.sv
hdl/sab_dpath.sv
hdl/suffix_automaton_builder_unit.sv
test/tb.sv
